// ----- sv/paf_pkg.sv -----
package paf_pkg;

  // default field widths
  localparam int POS_WIDTH_DEF = 32;
  localparam int OUT_WIDTH_DEF = 16;

  // normalized magnitude window and square root width
  localparam int MAG_WIDTH  = 31;
  localparam int ROOT_WIDTH = 32;

endpackage

// ----- sv/paf_norm.sv -----
module paf_norm #(
  parameter int IW = 33,
  parameter int SW = 1,
  parameter int OW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          ce,
  input  logic          in_valid,
  input  logic [IW-1:0] in_vec [3],
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [OW-1:0] out_vec [3],
  output logic [SW-1:0] out_side
);

  localparam int MW   = paf_pkg::MAG_WIDTH;
  localparam int RB   = paf_pkg::ROOT_WIDTH;
  localparam int SQW  = 2 * RB;
  localparam int REMW = RB + 4;
  localparam int W    = (IW > MW) ? IW : MW;
  localparam int LZB  = $clog2(W);
  localparam int F    = OW - 2;
  localparam int QB   = F + 1;
  localparam int NW   = MW + F + 1;
  localparam int D    = LZB + RB + QB + 6;
  localparam int CW   = SW + 3;
  localparam logic [QB-1:0] ONE_Q = QB'(1) << F;

  // valid bits and sign/sideband travel alongside the data
  logic [D-1:0]  vld;
  logic [CW-1:0] ctl [D];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[D-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      ctl[0] <= {in_side, in_vec[2][IW-1], in_vec[1][IW-1], in_vec[0][IW-1]};
      for (int j = 1; j < D; j++) begin
        ctl[j] <= ctl[j-1];
      end
    end
  end

  // magnitudes
  logic [IW-1:0] ab [3];

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        ab[i] <= in_vec[i][IW-1] ? (~in_vec[i] + 1'b1) : in_vec[i];
      end
    end
  end

  // largest magnitude
  logic [IW-1:0] m01, mx;
  logic [W-1:0]  sh_mag [LZB+1][3];
  logic [W-1:0]  sh_mx  [LZB+1];

  always_comb begin
    m01 = (ab[0] > ab[1]) ? ab[0] : ab[1];
    mx  = (m01 > ab[2]) ? m01 : ab[2];
  end

  // staged left normalization, one shift weight per stage
  always_ff @(posedge clk) begin
    if (ce) begin
      sh_mx[0] <= W'(mx);
      for (int i = 0; i < 3; i++) begin
        sh_mag[0][i] <= W'(ab[i]);
      end
      for (int k = 1; k <= LZB; k++) begin
        if ((sh_mx[k-1] & ~({W{1'b1}} >> (1 << (LZB - k)))) == '0) begin
          sh_mx[k] <= sh_mx[k-1] << (1 << (LZB - k));
          for (int i = 0; i < 3; i++) begin
            sh_mag[k][i] <= sh_mag[k-1][i] << (1 << (LZB - k));
          end
        end else begin
          sh_mx[k] <= sh_mx[k-1];
          for (int i = 0; i < 3; i++) begin
            sh_mag[k][i] <= sh_mag[k-1][i];
          end
        end
      end
    end
  end

  // squares of the windowed magnitudes
  logic [MW-1:0]   sq_a [3];
  logic [2*MW-1:0] sq_p [3];

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        sq_a[i] <= sh_mag[LZB][i][W-1 -: MW];
        sq_p[i] <= (2*MW)'(sh_mag[LZB][i][W-1 -: MW]) *
                   (2*MW)'(sh_mag[LZB][i][W-1 -: MW]);
      end
    end
  end

  // sum of squares
  logic [SQW-1:0] sm_s;
  logic [MW-1:0]  sm_a [3];

  always_ff @(posedge clk) begin
    if (ce) begin
      sm_s <= SQW'(sq_p[0]) + SQW'(sq_p[1]) + SQW'(sq_p[2]);
      for (int i = 0; i < 3; i++) begin
        sm_a[i] <= sq_a[i];
      end
    end
  end

  // square root, one root bit per stage
  logic [SQW-1:0]  rt_s    [RB];
  logic [REMW-1:0] rt_rem  [RB];
  logic [RB-1:0]   rt_root [RB];
  logic [MW-1:0]   rt_a    [RB][3];

  always_ff @(posedge clk) begin
    logic [SQW-1:0]  s_in;
    logic [REMW-1:0] rem_in, rem_sh, trial;
    logic [RB-1:0]   root_in;
    if (ce) begin
      for (int k = 0; k < RB; k++) begin
        if (k == 0) begin
          s_in    = sm_s;
          rem_in  = '0;
          root_in = '0;
          for (int i = 0; i < 3; i++) rt_a[k][i] <= sm_a[i];
        end else begin
          s_in    = rt_s[k-1];
          rem_in  = rt_rem[k-1];
          root_in = rt_root[k-1];
          for (int i = 0; i < 3; i++) rt_a[k][i] <= rt_a[k-1][i];
        end
        rem_sh = {rem_in[REMW-3:0], s_in[SQW-1 -: 2]};
        trial  = REMW'({root_in, 2'b01});
        if (rem_sh >= trial) begin
          rt_rem[k]  <= rem_sh - trial;
          rt_root[k] <= {root_in[RB-2:0], 1'b1};
        end else begin
          rt_rem[k]  <= rem_sh;
          rt_root[k] <= {root_in[RB-2:0], 1'b0};
        end
        rt_s[k] <= s_in << 2;
      end
    end
  end

  // numerator with half-divisor rounding term
  logic [NW-1:0] num [3];
  logic [RB-1:0] pr_rem [3];
  logic [QB-1:0] pr_low [3];
  logic [RB-1:0] pr_n;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = NW'({rt_a[RB-1][i], {F{1'b0}}}) + NW'(rt_root[RB-1] >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      pr_n <= rt_root[RB-1];
      for (int i = 0; i < 3; i++) begin
        pr_rem[i] <= RB'(num[i][NW-1:QB]);
        pr_low[i] <= num[i][QB-1:0];
      end
    end
  end

  // restoring division, one quotient bit per stage
  logic [RB-1:0] dv_rem [QB][3];
  logic [QB-1:0] dv_low [QB][3];
  logic [QB-1:0] dv_q   [QB][3];
  logic [RB-1:0] dv_n   [QB];

  always_ff @(posedge clk) begin
    logic [RB-1:0] rem_in, n_in;
    logic [QB-1:0] low_in, q_in;
    logic [RB:0]   rem_sh;
    if (ce) begin
      for (int k = 0; k < QB; k++) begin
        n_in = (k == 0) ? pr_n : dv_n[k-1];
        dv_n[k] <= n_in;
        for (int i = 0; i < 3; i++) begin
          if (k == 0) begin
            rem_in = pr_rem[i];
            low_in = pr_low[i];
            q_in   = '0;
          end else begin
            rem_in = dv_rem[k-1][i];
            low_in = dv_low[k-1][i];
            q_in   = dv_q[k-1][i];
          end
          rem_sh = {rem_in, low_in[QB-1]};
          if (rem_sh >= {1'b0, n_in}) begin
            dv_rem[k][i] <= RB'(rem_sh - {1'b0, n_in});
            dv_q[k][i]   <= {q_in[QB-2:0], 1'b1};
          end else begin
            dv_rem[k][i] <= rem_sh[RB-1:0];
            dv_q[k][i]   <= {q_in[QB-2:0], 1'b0};
          end
          dv_low[k][i] <= low_in << 1;
        end
      end
    end
  end

  // clamp and restore sign
  always_ff @(posedge clk) begin
    logic [QB-1:0] m;
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        m = (dv_q[QB-1][i] > ONE_Q) ? ONE_Q : dv_q[QB-1][i];
        out_vec[i] <= ctl[D-2][i] ? (~OW'(m) + 1'b1) : OW'(m);
      end
    end
  end

  assign out_valid = vld[D-1];
  assign out_side  = ctl[D-1][CW-1:3];

endmodule

// ----- sv/pointing_attitude_frame.sv -----
// the two normalizers take d at POS_WIDTH+1 bits and b at 2*OUT_WIDTH bits
// throughput: one item per cycle while not stalled; the square root and dividers are fully pipelined
// a stalled output freezes the whole pipeline, nothing is dropped or repeated
// reset (synchronous, rst high) clears all valid bits; data registers keep their contents
module pointing_attitude_frame #(
  parameter int POS_WIDTH = paf_pkg::POS_WIDTH_DEF,
  parameter int OUT_WIDTH = paf_pkg::OUT_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [POS_WIDTH-1:0] pos_x,
  input  logic signed [POS_WIDTH-1:0] pos_y,
  input  logic signed [POS_WIDTH-1:0] pos_z,
  input  logic signed [POS_WIDTH-1:0] target_x,
  input  logic signed [POS_WIDTH-1:0] target_y,
  input  logic signed [POS_WIDTH-1:0] target_z,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [OUT_WIDTH-1:0] col1_x,
  output logic signed [OUT_WIDTH-1:0] col1_y,
  output logic signed [OUT_WIDTH-1:0] col1_z,
  output logic signed [OUT_WIDTH-1:0] col2_x,
  output logic signed [OUT_WIDTH-1:0] col2_y,
  output logic signed [OUT_WIDTH-1:0] col2_z,
  output logic signed [OUT_WIDTH-1:0] col3_x,
  output logic signed [OUT_WIDTH-1:0] col3_y,
  output logic signed [OUT_WIDTH-1:0] col3_z,
  output logic                        degenerate
);

  localparam int OW  = OUT_WIDTH;
  localparam int F   = OW - 2;
  localparam int DW  = POS_WIDTH + 1;
  localparam int PRW = 2 * OW;
  localparam int CRW = 2 * OW + 1;
  localparam int SW2 = 3 * OW + 1;
  localparam logic [OW-1:0]         ONE_Q  = OW'(1) << F;
  localparam logic signed [PRW-1:0] ONE_SQ = PRW'(1) << (2 * F);
  localparam logic signed [CRW-1:0] HALF_C = CRW'(1) << (F - 1);
  localparam logic signed [CRW-1:0] ONE_C  = CRW'(1) << F;
  localparam logic signed [CRW-1:0] NONE_C = -(CRW'(1) << F);

  // round a Q2.2F term to Q1.F, half up, clamped
  function automatic logic [OW-1:0] round_q(input logic signed [CRW-1:0] p);
    logic signed [CRW-1:0] x, r;
    x = p + HALF_C;
    r = x >>> F;
    if (r > ONE_C) r = ONE_C;
    if (r < NONE_C) r = NONE_C;
    return OW'(r);
  endfunction

  // whole pipeline advances unless a finished item is held
  logic ce;
  assign ce       = !out_valid || !out_stall;
  assign in_stall = !ce;

  // pointing direction
  logic          t1_v, t1_dz;
  logic [DW-1:0] d [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      t1_v <= 1'b0;
    end else if (ce) begin
      t1_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      d[0]  <= DW'(target_x) - DW'(pos_x);
      d[1]  <= DW'(target_y) - DW'(pos_y);
      d[2]  <= DW'(target_z) - DW'(pos_z);
      t1_dz <= (target_x == pos_x) && (target_y == pos_y) && (target_z == pos_z);
    end
  end

  // first column
  logic          n1_v;
  logic [OW-1:0] c1 [3];
  logic [0:0]    n1_dz;

  paf_norm #(.IW(DW), .SW(1), .OW(OW)) u_norm_c1 (
    .clk      (clk),
    .rst      (rst),
    .ce       (ce),
    .in_valid (t1_v),
    .in_vec   (d),
    .in_side  (t1_dz),
    .out_valid(n1_v),
    .out_vec  (c1),
    .out_side (n1_dz)
  );

  // z axis projection products
  logic                  t2_v, t3_v, t2_dg;
  logic signed [PRW-1:0] p_zx, p_zy, p_zz;
  logic [OW-1:0]         t2_c1 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      t2_v <= 1'b0;
      t3_v <= 1'b0;
    end else if (ce) begin
      t2_v <= n1_v;
      t3_v <= t2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      p_zx  <= $signed(c1[2]) * $signed(c1[0]);
      p_zy  <= $signed(c1[2]) * $signed(c1[1]);
      p_zz  <= $signed(c1[2]) * $signed(c1[2]);
      t2_c1 <= c1;
      t2_dg <= n1_dz[0] || ((c1[0] == '0) && (c1[1] == '0));
    end
  end

  // z minus its part along the first column
  logic           t3_dg;
  logic [PRW-1:0] b [3];
  logic [OW-1:0]  t3_c1 [3];

  always_ff @(posedge clk) begin
    if (ce) begin
      b[0]  <= -p_zx;
      b[1]  <= -p_zy;
      b[2]  <= ONE_SQ - p_zz;
      t3_c1 <= t2_c1;
      t3_dg <= t2_dg;
    end
  end

  // third column
  logic           n2_v;
  logic [OW-1:0]  c3 [3];
  logic [SW2-1:0] n2_side;
  logic [OW-1:0]  n2_c1 [3];
  logic           n2_dg;

  paf_norm #(.IW(PRW), .SW(SW2), .OW(OW)) u_norm_c3 (
    .clk      (clk),
    .rst      (rst),
    .ce       (ce),
    .in_valid (t3_v),
    .in_vec   (b),
    .in_side  ({t3_dg, t3_c1[2], t3_c1[1], t3_c1[0]}),
    .out_valid(n2_v),
    .out_vec  (c3),
    .out_side (n2_side)
  );

  always_comb begin
    n2_c1[0] = n2_side[OW-1:0];
    n2_c1[1] = n2_side[2*OW-1:OW];
    n2_c1[2] = n2_side[3*OW-1:2*OW];
    n2_dg    = n2_side[SW2-1];
  end

  // cross product terms
  logic                  t4_v, t4_dg;
  logic signed [PRW-1:0] pa [3];
  logic signed [PRW-1:0] pb [3];
  logic [OW-1:0]         t4_c1 [3];
  logic [OW-1:0]         t4_c3 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      t4_v      <= 1'b0;
      out_valid <= 1'b0;
    end else if (ce) begin
      t4_v      <= n2_v;
      out_valid <= t4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      pa[0] <= $signed(c3[1]) * $signed(n2_c1[2]);
      pb[0] <= $signed(c3[2]) * $signed(n2_c1[1]);
      pa[1] <= $signed(c3[2]) * $signed(n2_c1[0]);
      pb[1] <= $signed(c3[0]) * $signed(n2_c1[2]);
      pa[2] <= $signed(c3[0]) * $signed(n2_c1[1]);
      pb[2] <= $signed(c3[1]) * $signed(n2_c1[0]);
      t4_c1 <= n2_c1;
      t4_c3 <= c3;
      t4_dg <= n2_dg;
    end
  end

  // second column and identity substitution
  always_ff @(posedge clk) begin
    if (ce) begin
      degenerate <= t4_dg;
      if (t4_dg) begin
        col1_x <= ONE_Q;
        col1_y <= '0;
        col1_z <= '0;
        col2_x <= '0;
        col2_y <= ONE_Q;
        col2_z <= '0;
        col3_x <= '0;
        col3_y <= '0;
        col3_z <= ONE_Q;
      end else begin
        col1_x <= t4_c1[0];
        col1_y <= t4_c1[1];
        col1_z <= t4_c1[2];
        col2_x <= round_q(CRW'(pa[0]) - CRW'(pb[0]));
        col2_y <= round_q(CRW'(pa[1]) - CRW'(pb[1]));
        col2_z <= round_q(CRW'(pa[2]) - CRW'(pb[2]));
        col3_x <= t4_c3[0];
        col3_y <= t4_c3[1];
        col3_z <= t4_c3[2];
      end
    end
  end

endmodule
